// ===== design/carb_pkg.sv =====
// ----------------------------------------------------------------------------
// carb_pkg: shared definitions for the chunked audio ring buffer
// Field widths, register codes, item kinds, result codes, the controller
// state type and the command and status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package carb_pkg;

	// Default ring size; the top level exposes it as a parameter.
	localparam int RING_CHUNKS_DEF  = 8;

	// Chunk geometry. Both are powers of two, so a store address is the
	// concatenation {slot, frame, channel}.
	localparam int MAX_CHUNK_FRAMES = 256;
	localparam int FRAME_W          = 8;
	localparam int MAX_CHANNELS     = 8;
	localparam int CHAN_W           = 3;
	localparam int SAMPLE_BITS      = 16;

	// Item field widths.
	localparam int KIND_W           = 2;
	localparam int STATUS_W         = 2;

	// Configuration registers.
	localparam int CFG_FRAMES_W     = 9;
	localparam int CFG_CHANS_W      = 4;
	localparam logic [CFG_FRAMES_W-1:0] CHUNK_FRAMES_RST = 9'd256;
	localparam logic [CFG_CHANS_W-1:0]  CHANNELS_RST     = 4'd2;

	// APB port geometry.
	localparam int PADDR_W          = 3;
	localparam int PDATA_W          = 32;

	// Register index codes.
	typedef enum logic [0:0] {
		REG_CHUNK_FRAMES = 1'b0,
		REG_CHANNELS     = 1'b1
	} reg_idx_t;

	// Item kinds.
	typedef enum logic [KIND_W-1:0] {
		KIND_WRITE  = 2'd0,
		KIND_COMMIT = 2'd1,
		KIND_READ   = 2'd2
	} kind_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK       = 2'd0,
		STATUS_OVERFLOW = 2'd1,
		STATUS_UNDERRUN = 2'd2
	} status_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic clear_en;
		logic accept;
		logic read_done;
	} carb_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic clear_done;
		logic res_free;
	} carb_sts_t;

	// One result item.
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_out;
		status_t                       status;
		logic                          last_of_chunk;
	} result_t;

endpackage

`default_nettype wire

// ===== design/carb_in_if.sv =====
// ----------------------------------------------------------------------------
// carb_in_if: input item channel
// Valid/ready channel that carries one write, commit or read item.
// ----------------------------------------------------------------------------
`default_nettype none

interface carb_in_if
	import carb_pkg::*;
();

	logic                          valid;
	logic                          ready;
	logic [KIND_W-1:0]             kind;
	logic [CHAN_W-1:0]             channel;
	logic [FRAME_W-1:0]            offset;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output kind, output channel, output offset,
		output sample, input ready);
	modport sink (input valid, input kind, input channel, input offset,
		input sample, output ready);
endinterface

`default_nettype wire

// ===== design/carb_out_if.sv =====
// ----------------------------------------------------------------------------
// carb_out_if: result channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface carb_out_if
	import carb_pkg::*;
();

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic [STATUS_W-1:0]           status;
	logic                          last_of_chunk;

	modport source (output valid, output sample_out, output status,
		output last_of_chunk, input ready);
	modport sink (input valid, input sample_out, input status,
		input last_of_chunk, output ready);
endinterface

`default_nettype wire

// ===== design/carb_ram.sv =====
// ----------------------------------------------------------------------------
// carb_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module carb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/carb_ctrl.sv =====
// ----------------------------------------------------------------------------
// carb_ctrl: controller state machine
// Runs the store clearing sweep after reset, accepts items when the result
// stage has room and waits in the read state on the store for each read item.
// ----------------------------------------------------------------------------
`default_nettype none

module carb_ctrl
	import carb_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      in_is_read,
	input  wire carb_sts_t sts,
	output logic           in_ready,
	output carb_cmd_t      cmd
);

	state_t state_q;
	state_t state_d;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid && in_ready && in_is_read) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready      = 1'b0;
		cmd.clear_en  = 1'b0;
		cmd.read_done = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_en = 1'b1;
			end
			ST_IDLE: begin
				in_ready = sts.res_free;
			end
			ST_READ: begin
				cmd.read_done = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
		cmd.accept = in_ready && in_valid;
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// A read always completes in the cycle after it was accepted.
	a_read_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |=> (state_q == ST_IDLE))
		else $error("read state held for more than one cycle");

	// No transaction is taken while the store is being cleared.
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !cmd.accept)
		else $error("transaction accepted during clearing sweep");

	// A transaction is only taken while the result stage has room.
	a_accept_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> sts.res_free)
		else $error("transaction accepted with the result stage full");

endmodule

`default_nettype wire

// ===== design/carb_dp.sv =====
// ----------------------------------------------------------------------------
// carb_dp: ring buffer datapath
// Slot and read position registers, the sample store, the clearing counter
// and a two-entry result stage (output register and skid register).
// ----------------------------------------------------------------------------
`default_nettype none

module carb_dp
	import carb_pkg::*;
#(
	parameter int RING_CHUNKS = RING_CHUNKS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire carb_cmd_t                     cmd,
	output carb_sts_t                          sts,
	input  wire logic [CFG_FRAMES_W-1:0]       cfg_frames,
	input  wire logic [CFG_CHANS_W-1:0]        cfg_chans,
	input  wire logic [KIND_W-1:0]             kind,
	input  wire logic [CHAN_W-1:0]             channel,
	input  wire logic [FRAME_W-1:0]            offset,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	input  wire logic                          out_ready,
	output logic                               out_valid,
	output result_t                            out_data
);

	localparam int SLOT_W = $clog2(RING_CHUNKS);
	localparam int DEPTH  = RING_CHUNKS * MAX_CHUNK_FRAMES * MAX_CHANNELS;
	localparam int ADDR_W = SLOT_W + FRAME_W + CHAN_W;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_CHUNKS - 1);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
	localparam logic [CFG_FRAMES_W-1:0] FRAMES_MAX = CFG_FRAMES_W'(MAX_CHUNK_FRAMES);
	localparam logic [CFG_CHANS_W-1:0]  CHANS_MAX  = CFG_CHANS_W'(MAX_CHANNELS);

	logic [SLOT_W-1:0]       write_slot_q;
	logic [SLOT_W-1:0]       read_slot_q;
	logic [FRAME_W-1:0]      read_frame_q;
	logic [CHAN_W-1:0]       read_channel_q;
	logic                    underrun_q;
	logic [ADDR_W-1:0]       clr_addr_q;
	logic                    rd_underrun_s1;
	logic                    rd_last_s1;

	logic [CFG_FRAMES_W-1:0] eff_frames;
	logic [CFG_CHANS_W-1:0]  eff_chans;
	logic [SLOT_W-1:0]       next_wslot;
	logic [SLOT_W-1:0]       next_rslot;
	logic                    underrun_now;
	logic                    chan_wrap;
	logic                    frame_wrap;
	logic                    wr_ok;
	logic                    overflow;
	logic                    is_read;

	logic                    ram_we;
	logic [ADDR_W-1:0]       ram_waddr;
	logic [SAMPLE_BITS-1:0]  ram_wdata;
	logic                    ram_re;
	logic [ADDR_W-1:0]       ram_raddr;
	logic [SAMPLE_BITS-1:0]  ram_rdata;

	logic                    push;
	result_t                 push_data;
	logic                    pop;
	logic                    out_valid_q;
	logic                    skid_valid_q;
	result_t                 out_q;
	result_t                 skid_q;

	// Effective chunk size and channel count, clamped to the legal range.
	always_comb begin
		if (cfg_frames == '0) begin
			eff_frames = CFG_FRAMES_W'(1);
		end else if (cfg_frames > FRAMES_MAX) begin
			eff_frames = FRAMES_MAX;
		end else begin
			eff_frames = cfg_frames;
		end
		if (cfg_chans == '0) begin
			eff_chans = CFG_CHANS_W'(1);
		end else if (cfg_chans > CHANS_MAX) begin
			eff_chans = CHANS_MAX;
		end else begin
			eff_chans = cfg_chans;
		end
	end

	// Slot increments, position wrap tests and the underrun decision.
	always_comb begin
		next_wslot   = (write_slot_q == LAST_SLOT) ? '0 : write_slot_q + 1'b1;
		next_rslot   = (read_slot_q == LAST_SLOT) ? '0 : read_slot_q + 1'b1;
		overflow     = (kind == KIND_COMMIT) && (next_wslot == read_slot_q);
		is_read      = (kind == KIND_READ);
		wr_ok        = ({1'b0, offset} < eff_frames) && ({1'b0, channel} < eff_chans);
		chan_wrap    = ({1'b0, read_channel_q} + CFG_CHANS_W'(1)) >= eff_chans;
		frame_wrap   = ({1'b0, read_frame_q} + CFG_FRAMES_W'(1)) >= eff_frames;
		if (read_frame_q == '0 && read_channel_q == '0) begin
			underrun_now = (read_slot_q == write_slot_q);
		end else begin
			underrun_now = underrun_q;
		end
	end

	// Store ports: the clearing sweep owns the write port until it is done.
	always_comb begin
		ram_we    = cmd.clear_en || (cmd.accept && (kind == KIND_WRITE) && wr_ok);
		ram_waddr = cmd.clear_en ? clr_addr_q : {write_slot_q, offset, channel};
		ram_wdata = cmd.clear_en ? '0 : sample;
		ram_re    = cmd.accept && is_read;
		ram_raddr = {read_slot_q, read_frame_q, read_channel_q};
	end

	carb_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign sts.clear_done = cmd.clear_en && (clr_addr_q == LAST_ADDR);
	assign sts.res_free   = !skid_valid_q;

	// Clearing counter and ring pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q     <= '0;
			write_slot_q   <= '0;
			read_slot_q    <= '0;
			read_frame_q   <= '0;
			read_channel_q <= '0;
			underrun_q     <= 1'b0;
		end else begin
			if (cmd.clear_en && !sts.clear_done) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cmd.accept) begin
				case (kind)
					KIND_COMMIT: begin
						if (!overflow) begin
							write_slot_q <= next_wslot;
						end
					end
					KIND_READ: begin
						underrun_q <= underrun_now;
						if (chan_wrap) begin
							read_channel_q <= '0;
							if (frame_wrap) begin
								read_frame_q <= '0;
								if (!underrun_now) begin
									read_slot_q <= next_rslot;
								end
							end else begin
								read_frame_q <= read_frame_q + 1'b1;
							end
						end else begin
							read_channel_q <= read_channel_q + 1'b1;
						end
					end
					default: begin
						underrun_q <= underrun_q;
					end
				endcase
			end
		end
	end

	// Result details of a read, held while the store is read.
	always_ff @(posedge clk) begin
		if (ram_re) begin
			rd_underrun_s1 <= underrun_now;
			rd_last_s1     <= chan_wrap && frame_wrap;
		end
	end

	// Result formed at acceptance for writes, commits and unknown kinds, in the
	// cycle after acceptance for reads.
	always_comb begin
		push = cmd.read_done || (cmd.accept && !is_read);
		if (cmd.read_done) begin
			push_data.sample_out    = rd_underrun_s1 ? '0 : ram_rdata;
			push_data.status        = rd_underrun_s1 ? STATUS_UNDERRUN : STATUS_OK;
			push_data.last_of_chunk = rd_last_s1;
		end else begin
			push_data.sample_out    = '0;
			push_data.status        = overflow ? STATUS_OVERFLOW : STATUS_OK;
			push_data.last_of_chunk = 1'b0;
		end
	end

	assign pop = out_valid_q && out_ready;

	// Result stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop || !out_valid_q) begin
			out_valid_q  <= skid_valid_q || push;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Result stage payload.
	always_ff @(posedge clk) begin
		if (pop || !out_valid_q) begin
			out_q <= skid_valid_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// The skid register fills only behind a held output register.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register valid with output register empty");

	// A waiting result in the skid register is never lost under a stall.
	a_skid_held: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !out_ready) |=> skid_valid_q)
		else $error("skid register dropped a result under stall");

	// Read completion always follows a store read issued the cycle before.
	a_read_issued: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.read_done |-> $past(ram_re))
		else $error("read completed without a store read");

endmodule

`default_nettype wire

// ===== design/chunked_audio_ring_buffer_unit.sv =====
// ----------------------------------------------------------------------------
// chunked_audio_ring_buffer_unit: multichannel audio FIFO of whole chunks
// Items arrive on the item channel (valid/ready): write sample, commit chunk
// or read next sample. Each accepted item yields one result on the result
// channel (valid/ready): the sample read, a status (ok, overflow, underrun)
// and a last-of-chunk flag. Chunk size and channel count are set over the APB
// port at byte addresses 0 and 4. The user is to write them only while the
// block is idle; the block does not enforce this. Results pass the output
// register, read results first the store's registered read port. Writes and
// commits can be taken every cycle while the result stage has room, but no
// item while a read waits on the store. After reset the store is swept to
// zero, one entry per cycle, and ready stays low during that sweep;
// configuration writes are taken throughout. A two-entry result stage lets
// one more transaction be taken while the receiver stalls; after that ready
// drops until a result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module chunked_audio_ring_buffer_unit
	import carb_pkg::*;
#(
	parameter int RING_CHUNKS = RING_CHUNKS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	carb_in_if.sink                 item,
	carb_out_if.source              result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	logic [CFG_FRAMES_W-1:0] chunk_frames_q;
	logic [CFG_CHANS_W-1:0]  channels_q;
	reg_idx_t                reg_idx;
	logic                    cfg_write;
	carb_cmd_t               cmd;
	carb_sts_t               sts;
	logic                    in_ready;
	logic                    out_valid;
	result_t                 out_data;

	// Register decode: one register per 32-bit word.
	assign reg_idx   = reg_idx_t'(paddr[2]);
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_frames_q <= CHUNK_FRAMES_RST;
			channels_q     <= CHANNELS_RST;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_CHUNK_FRAMES: chunk_frames_q <= pwdata[CFG_FRAMES_W-1:0];
				REG_CHANNELS:     channels_q     <= pwdata[CFG_CHANS_W-1:0];
				default:          channels_q     <= channels_q;
			endcase
		end
	end

	// Register read back.
	always_comb begin
		unique case (reg_idx)
			REG_CHUNK_FRAMES: prdata = PDATA_W'(chunk_frames_q);
			REG_CHANNELS:     prdata = PDATA_W'(channels_q);
			default:          prdata = '0;
		endcase
	end

	carb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (item.valid),
		.in_is_read (item.kind == KIND_READ),
		.sts        (sts),
		.in_ready   (in_ready),
		.cmd        (cmd)
	);

	carb_dp #(
		.RING_CHUNKS (RING_CHUNKS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_frames (chunk_frames_q),
		.cfg_chans  (channels_q),
		.kind       (item.kind),
		.channel    (item.channel),
		.offset     (item.offset),
		.sample     (item.sample),
		.out_ready  (result.ready),
		.out_valid  (out_valid),
		.out_data   (out_data)
	);

	// Channel hookup.
	assign item.ready           = in_ready;
	assign result.valid         = out_valid;
	assign result.sample_out    = out_data.sample_out;
	assign result.status        = out_data.status;
	assign result.last_of_chunk = out_data.last_of_chunk;

endmodule

`default_nettype wire

// ===== tb/chunked_audio_ring_buffer_unit_test.sv =====
// ----------------------------------------------------------------------------
// chunked_audio_ring_buffer_unit_test: self-checking bench for the audio ring
// Drives write, commit and read transactions into the chunk ring under
// random back-pressure on both channels. It sweeps chunk geometry over the
// APB port, including the out-of-range register values. A scoreboard
// predicts every result (sample, status, last-of-chunk) from its own copy of
// the ring and compares each result, in order, with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module chunked_audio_ring_buffer_unit_test
	import carb_pkg::*;
();

	localparam int SLOT_W       = $clog2(RING_CHUNKS_DEF);
	localparam int STORE_DEPTH  = RING_CHUNKS_DEF * MAX_CHUNK_FRAMES * MAX_CHANNELS;
	localparam int NUM_PHASES   = 12;
	localparam int PHASE_ITEMS  = 105;
	localparam int DRAIN_CYCLES = 6;
	localparam int LIMIT_CYCLES = 400000;

	// The item field can carry a code that names no operation.
	localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

	// Scoreboard: tracks the ring and queues the predicted results.
	class audio_ring_scoreboard;
		logic signed [SAMPLE_BITS-1:0] store [STORE_DEPTH];
		logic [SLOT_W-1:0]             wr_slot;
		logic [SLOT_W-1:0]             rd_slot;
		logic [FRAME_W-1:0]            rd_frame;
		logic [CHAN_W-1:0]             rd_chan;
		logic                          underrun;
		logic [CFG_FRAMES_W-1:0]       cfg_frames;
		logic [CFG_CHANS_W-1:0]        cfg_chans;
		result_t                       pending_results[$];
		int items, results, reads, overflows, silent_reads, errors;

		function new();
			foreach (store[i]) store[i] = '0;
			wr_slot    = '0;
			rd_slot    = '0;
			rd_frame   = '0;
			rd_chan    = '0;
			underrun   = 1'b0;
			cfg_frames = CHUNK_FRAMES_RST;
			cfg_chans  = CHANNELS_RST;
			items = 0; results = 0; reads = 0;
			overflows = 0; silent_reads = 0; errors = 0;
		endfunction

		// Register values outside the legal range are clamped.
		function int frames_used();
			if (cfg_frames == 0) return 1;
			if (cfg_frames > MAX_CHUNK_FRAMES) return MAX_CHUNK_FRAMES;
			return int'(cfg_frames);
		endfunction

		function int chans_used();
			if (cfg_chans == 0) return 1;
			if (cfg_chans > MAX_CHANNELS) return MAX_CHANNELS;
			return int'(cfg_chans);
		endfunction

		function void write_reg(reg_idx_t idx, logic [PDATA_W-1:0] data);
			case (idx)
				REG_CHUNK_FRAMES: cfg_frames = data[CFG_FRAMES_W-1:0];
				REG_CHANNELS:     cfg_chans  = data[CFG_CHANS_W-1:0];
				default: ;
			endcase
		endfunction

		// Applies one accepted transaction and queues the result it causes.
		function void take_item(logic [KIND_W-1:0] kind, logic [CHAN_W-1:0] ch,
				logic [FRAME_W-1:0] off, logic signed [SAMPLE_BITS-1:0] smp);
			result_t           res;
			int                nf;
			int                nc;
			logic [SLOT_W-1:0] next_slot;
			nf = frames_used();
			nc = chans_used();
			res.sample_out    = '0;
			res.status        = STATUS_OK;
			res.last_of_chunk = 1'b0;
			items++;
			case (kind)
				KIND_WRITE: begin
					if (int'(off) < nf && int'(ch) < nc)
						store[{wr_slot, off, ch}] = smp;
				end
				KIND_COMMIT: begin
					next_slot = wr_slot + 1'b1;
					if (next_slot == rd_slot) begin
						res.status = STATUS_OVERFLOW;
						overflows++;
					end else begin
						wr_slot = next_slot;
					end
				end
				KIND_READ: begin
					reads++;
					// The underrun decision is taken once per chunk, at its first sample.
					if (rd_frame == 0 && rd_chan == 0)
						underrun = (rd_slot == wr_slot);
					if (underrun) begin
						res.status = STATUS_UNDERRUN;
						silent_reads++;
					end else begin
						res.sample_out = store[{rd_slot, rd_frame, rd_chan}];
					end
					if (int'(rd_chan) + 1 >= nc) begin
						rd_chan = '0;
						if (int'(rd_frame) + 1 >= nf) begin
							rd_frame          = '0;
							res.last_of_chunk = 1'b1;
							if (!underrun)
								rd_slot = rd_slot + 1'b1;
						end else begin
							rd_frame = rd_frame + 1'b1;
						end
					end else begin
						rd_chan = rd_chan + 1'b1;
					end
				end
				default: ;
			endcase
			pending_results.push_back(res);
		endfunction

		// Compares one accepted result with the oldest prediction.
		function void check_result(logic signed [SAMPLE_BITS-1:0] smp,
				logic [STATUS_W-1:0] st, logic last);
			result_t want;
			results++;
			if (pending_results.size() == 0) begin
				$error("unexpected result: sample_out %0d status %0d last_of_chunk %0d",
					smp, st, last);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (smp !== want.sample_out) begin
				$error("sample_out: expected %0d, actual %0d", want.sample_out, smp);
				errors++;
			end
			if (st !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, st);
				errors++;
			end
			if (last !== want.last_of_chunk) begin
				$error("last_of_chunk: expected %0d, actual %0d", want.last_of_chunk, last);
				errors++;
			end
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;
	int                  tx_idle;
	int                  rx_idle;
	int                  cycle_count;
	int                  geometries;
	audio_ring_scoreboard sb;

	carb_in_if  item_ch ();
	carb_out_if result_ch ();

	chunked_audio_ring_buffer_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver back-pressure.
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= ($urandom_range(0, 99) >= rx_idle);
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
			sb.check_result(result_ch.sample_out, result_ch.status, result_ch.last_of_chunk);
	end

	function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0:       return 16'sh8000;
			1:       return 16'sh7fff;
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	// Presents one transaction and holds it until the block takes it.
	task automatic drive_item(logic [KIND_W-1:0] kind, logic [CHAN_W-1:0] ch,
			logic [FRAME_W-1:0] off, logic signed [SAMPLE_BITS-1:0] smp);
		while ($urandom_range(0, 99) < tx_idle) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid   <= 1'b1;
		item_ch.kind    <= kind;
		item_ch.channel <= ch;
		item_ch.offset  <= off;
		item_ch.sample  <= smp;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		sb.take_item(kind, ch, off, smp);
		@(negedge clk);
	endtask

	// Stops sending and waits until every predicted result has come out.
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// APB write: setup phase, access phase, then the bus returns to idle.
	task automatic apb_write(reg_idx_t idx, logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		sb.write_reg(idx, data);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// Sets the chunk geometry with junk in the unused upper register bits.
	task automatic set_geometry(int frames, int chans);
		logic [PDATA_W-1:0] data;
		drain();
		data = $urandom();
		data[CFG_FRAMES_W-1:0] = CFG_FRAMES_W'(frames);
		apb_write(REG_CHUNK_FRAMES, data);
		data = $urandom();
		data[CFG_CHANS_W-1:0] = CFG_CHANS_W'(chans);
		apb_write(REG_CHANNELS, data);
		geometries++;
	endtask

	// Fills one chunk in frame order, leaving an occasional hole, and commits it.
	task automatic produce_chunk();
		int nf;
		int nc;
		nf = sb.frames_used();
		nc = sb.chans_used();
		for (int f = 0; f < nf; f++) begin
			for (int c = 0; c < nc; c++) begin
				if ($urandom_range(0, 19) != 0)
					drive_item(KIND_WRITE, CHAN_W'(c), FRAME_W'(f), rand_sample());
			end
		end
		drive_item(KIND_COMMIT, CHAN_W'($urandom_range(0, 7)),
			FRAME_W'($urandom_range(0, 255)), rand_sample());
	endtask

	task automatic consume(int count);
		repeat (count)
			drive_item(KIND_READ, CHAN_W'($urandom_range(0, 7)),
				FRAME_W'($urandom_range(0, 255)), rand_sample());
	endtask

	// One random step: mostly whole chunks in and out, some noise and pauses.
	task automatic random_action();
		int pick;
		int chunk_len;
		pick      = $urandom_range(0, 99);
		chunk_len = sb.frames_used() * sb.chans_used();
		if (pick < 38) begin
			produce_chunk();
		end else if (pick < 73) begin
			if ($urandom_range(0, 1) != 0)
				consume(chunk_len);
			else
				consume($urandom_range(1, chunk_len));
		end else if (pick < 88) begin
			drive_item(KIND_W'($urandom_range(0, 3)), CHAN_W'($urandom_range(0, 7)),
				FRAME_W'($urandom_range(0, 255)), rand_sample());
		end else if (pick < 97) begin
			repeat ($urandom_range(1, 3))
				drive_item(KIND_COMMIT, CHAN_W'($urandom_range(0, 7)),
					FRAME_W'($urandom_range(0, 255)), rand_sample());
		end else begin
			drain();
		end
	endtask

	// Main sequence.
	initial begin
		int target;
		sb              = new();
		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		item_ch.valid   = 1'b0;
		item_ch.kind    = '0;
		item_ch.channel = '0;
		item_ch.offset  = '0;
		item_ch.sample  = '0;
		cycle_count     = 0;
		geometries      = 1;
		tx_idle         = 13;
		rx_idle         = 72;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset geometry: read of an empty ring, corner
		// writes, a channel beyond the chunk and the unknown kind.
		drive_item(KIND_READ, 3'd0, 8'd0, 16'sh0000);
		drive_item(KIND_WRITE, 3'd1, 8'd255, 16'sh7fff);
		drive_item(KIND_WRITE, 3'd0, 8'd0, 16'sh8000);
		drive_item(KIND_WRITE, 3'd7, 8'd0, 16'sh5a5a);
		drive_item(KIND_UNKNOWN, 3'd7, 8'd255, 16'shffff);
		drive_item(KIND_COMMIT, 3'd0, 8'd0, 16'sh0000);
		// Shrink the geometry in the middle of a silent chunk.
		set_geometry(1, 1);
		consume(3);
		drive_item(KIND_WRITE, 3'd0, 8'd1, 16'sh1234);
		// Fill the ring: the final commit finds it full and is dropped.
		repeat (8) drive_item(KIND_COMMIT, 3'd0, 8'd0, 16'sh0000);
		consume(2);

		// Random phases over several geometries and three idle patterns.
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p == 4) begin
				tx_idle = 72;
				rx_idle = 13;
			end else if (p == 8) begin
				tx_idle = 0;
				rx_idle = 0;
			end
			case (p)
				0:       set_geometry(0, 0);
				1:       set_geometry(511, 1);
				2:       set_geometry(1, 15);
				3:       set_geometry(3, 8);
				default: set_geometry($urandom_range(1, 6), $urandom_range(1, 4));
			endcase
			target = sb.items + PHASE_ITEMS;
			if (p == 1) begin
				produce_chunk();
				consume(sb.frames_used() * sb.chans_used());
			end
			while (sb.items < target) random_action();
		end

		drain();
		$display("Run covered %0d transactions over %0d geometries: %0d reads, %0d silent.",
			sb.items, geometries, sb.reads, sb.silent_reads);
		$display("Dropped commits on a full ring: %0d.", sb.overflows);
		if (sb.errors == 0 && sb.results == sb.items && sb.pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
